// File: hdl/bfa_pkg.sv
package bfa_pkg;

  // Default bitmap depth in words.
  localparam int unsigned BITMAP_WORDS_DEF = 64;

  // Fixed geometry: 64-bit bitmap words, 4 KiB frames, 32-bit addresses.
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned BIT_W       = 6;
  localparam int unsigned FRAME_SHIFT = 12;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned IN_DATA_W   = 64;

  // Reset value of the words-in-use register.
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic [WORD_BITS-1:0] WORD_FULL = '1;

  typedef enum logic [1:0] {
    OP_ALLOC          = 2'd0,
    OP_RELEASE        = 2'd1,
    OP_FREE_REGION    = 2'd2,
    OP_RESERVE_REGION = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_BAD_ADDR = 2'd2,
    ST_NOT_USED = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic prep;
    logic run;
    logic restart;
    logic out_load;
  } bfa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic finished;
    logic retry;
    logic out_free;
  } bfa_sts_t;

endpackage

// File: hdl/bitmap_frame_allocator_top.sv
// Allocate scans the bitmap from the search start up to the words in use, and wraps once to
// word zero when no clear bit was found and the start was not word zero; one bitmap word is read per cycle from memory.
// Release touches at most one word; a region touches its words, one read-modify-write per cycle.
// One request is worked at a time; the next is accepted while a result waits in the output.
// After reset a clearing pass writes every bitmap word to all used, during which no request
// is accepted; configuration writes are taken at any time.
module bitmap_frame_allocator_top #(
  parameter int unsigned BITMAP_WORDS = bfa_pkg::BITMAP_WORDS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // byte_address [31:0], byte_length [63:32]
  input  logic [bfa_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // opcode [1:0]
  input  logic [1:0]                     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // frame_address [31:0]
  output logic [bfa_pkg::ADDR_W-1:0]     m_axis_tdata_o,
  // status [1:0]
  output logic [1:0]                     m_axis_tuser_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bfa_pkg::CFG_W-1:0]      cfg_data_i
);
  import bfa_pkg::*;

  bfa_cmd_t cmd;
  bfa_sts_t sts;

  // The words-in-use register always takes a write.
  assign cfg_ready_o = 1'b1;

  bfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bfa_datapath #(
    .BITMAP_WORDS (BITMAP_WORDS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_opcode_i  (opcode_e'(s_axis_tuser_i)),
    .in_addr_i    (s_axis_tdata_i[ADDR_W-1:0]),
    .in_len_i     (s_axis_tdata_i[2*ADDR_W-1:ADDR_W]),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_addr_o   (m_axis_tdata_o),
    .out_status_o (m_axis_tuser_o)
  );

endmodule

// File: hdl/bfa_datapath.sv
module bfa_datapath #(
  parameter int unsigned BITMAP_WORDS = bfa_pkg::BITMAP_WORDS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bfa_pkg::bfa_cmd_t           cmd_i,
  output bfa_pkg::bfa_sts_t           sts_o,
  input  bfa_pkg::opcode_e            in_opcode_i,
  input  logic [bfa_pkg::ADDR_W-1:0]  in_addr_i,
  input  logic [bfa_pkg::ADDR_W-1:0]  in_len_i,
  input  logic                        cfg_valid_i,
  input  logic [bfa_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [bfa_pkg::ADDR_W-1:0]  out_addr_o,
  output logic [1:0]                  out_status_o
);
  import bfa_pkg::*;

  localparam int unsigned WIDX = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int unsigned WCNT = $clog2(BITMAP_WORDS + 1);
  localparam int unsigned CW   = 33;
  localparam int unsigned WLO  = FRAME_SHIFT + BIT_W;

  // Bitmap memory: one write and one registered read per cycle.
  logic [WORD_BITS-1:0] mem [BITMAP_WORDS];

  logic [CFG_W-1:0]     cfg_q;
  opcode_e              op_q;
  logic [ADDR_W-1:0]    addr_q, len_q;
  logic [WCNT-1:0]      ptr_q, ptr_d, lim_q, lim_d;
  logic [WIDX-1:0]      start_q, start_d;
  logic                 rvld_q;
  logic [WIDX-1:0]      rtag_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic [BIT_W-1:0]     bit_q, bit_d, hm1_q, hm1_d;
  logic [WIDX-1:0]      first_word_q, first_word_d, last_word_q, last_word_d;
  logic [ADDR_W-1:0]    res_addr_q, res_addr_d;
  status_e              res_status_q, res_status_d;
  logic                 out_valid_q;
  logic [ADDR_W-1:0]    out_addr_q;
  status_e              out_status_q;

  logic [WCNT-1:0]      live_words;
  logic [CW-1:0]        frames;
  logic                 hit, issue, finished, retry;

  // Effective word count saturates at the bitmap depth.
  assign live_words = (32'(cfg_q) > BITMAP_WORDS) ? WCNT'(BITMAP_WORDS) : WCNT'(cfg_q);
  assign frames     = CW'(live_words) << BIT_W;

  // Release checks: alignment and range, word and bit of the frame.
  logic [ADDR_W-WLO-1:0] rel_word;
  logic                  rel_bad;
  assign rel_word = addr_q[ADDR_W-1:WLO];
  assign rel_bad  = (addr_q[FRAME_SHIFT-1:0] != '0) || (CW'(rel_word) >= CW'(live_words));

  // Region bounds: count rounded per opcode, end clipped to the frames in use.
  logic          round_up;
  logic [CW-1:0] first_frame, reg_sum, reg_end, reg_end_m1;
  logic          reg_empty;
  assign round_up    = (op_q == OP_RESERVE_REGION) && (len_q[FRAME_SHIFT-1:0] != '0);
  assign first_frame = CW'(addr_q[ADDR_W-1:FRAME_SHIFT]);
  assign reg_sum     = first_frame + CW'(len_q[ADDR_W-1:FRAME_SHIFT]) + CW'(round_up);
  assign reg_end     = (reg_sum > frames) ? frames : reg_sum;
  assign reg_empty   = first_frame >= reg_end;
  assign reg_end_m1  = reg_end - CW'(1);

  // Read issue and scan termination.
  assign hit      = rvld_q && (op_q == OP_ALLOC) && (rdata_q != WORD_FULL);
  assign issue    = cmd_i.run && !hit && (ptr_q < lim_q);
  assign finished = hit || (ptr_q >= lim_q);
  assign retry    = (op_q == OP_ALLOC) && !hit && (start_q != '0);

  // Lowest clear bit of the word just read.
  logic [BIT_W-1:0] zero_bit;
  always_comb begin
    zero_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!rdata_q[i]) begin
        zero_bit = BIT_W'(i);
      end
    end
  end

  // Region mask for the word just read.
  logic [BIT_W-1:0]     lo_eff, hm1_eff;
  logic [WORD_BITS-1:0] reg_mask;
  assign lo_eff   = (rtag_q == first_word_q) ? bit_q : '0;
  assign hm1_eff  = (rtag_q == last_word_q) ? hm1_q : BIT_W'(WORD_BITS - 1);
  assign reg_mask = (WORD_FULL << lo_eff) & (WORD_FULL >> (BIT_W'(WORD_BITS - 1) - hm1_eff));

  // Next-state logic for pointers, search start, bounds and result.
  logic                 wr_en;
  logic [WIDX-1:0]      wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  always_comb begin
    ptr_d        = ptr_q;
    lim_d        = lim_q;
    start_d      = start_q;
    bit_d        = bit_q;
    hm1_d        = hm1_q;
    first_word_d = first_word_q;
    last_word_d  = last_word_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    wr_en        = 1'b0;
    wr_addr      = rtag_q;
    wr_data      = rdata_q;

    if (cmd_i.clear) begin
      wr_en   = 1'b1;
      wr_addr = ptr_q[WIDX-1:0];
      wr_data = WORD_FULL;
      ptr_d   = ptr_q + WCNT'(1);
    end

    if (cmd_i.load) begin
      res_addr_d   = '0;
      res_status_d = ST_OK;
    end

    if (cmd_i.prep) begin
      bit_d        = addr_q[WLO-1:FRAME_SHIFT];
      hm1_d        = reg_end_m1[BIT_W-1:0];
      first_word_d = addr_q[WLO+WIDX-1:WLO];
      last_word_d  = reg_end_m1[BIT_W+WIDX-1:BIT_W];
      unique case (op_q)
        OP_ALLOC: begin
          ptr_d = WCNT'(start_q);
          lim_d = live_words;
        end
        OP_RELEASE: begin
          if (rel_bad) begin
            ptr_d        = '0;
            lim_d        = '0;
            res_status_d = ST_BAD_ADDR;
          end else begin
            ptr_d = WCNT'(rel_word[WIDX-1:0]);
            lim_d = WCNT'(rel_word[WIDX-1:0]) + WCNT'(1);
          end
        end
        OP_FREE_REGION, OP_RESERVE_REGION: begin
          if (reg_empty) begin
            ptr_d = '0;
            lim_d = '0;
          end else begin
            ptr_d = WCNT'(addr_q[WLO+WIDX-1:WLO]);
            lim_d = WCNT'(reg_end_m1[BIT_W+WIDX-1:BIT_W]) + WCNT'(1);
          end
        end
      endcase
    end

    if (issue) begin
      ptr_d = ptr_q + WCNT'(1);
    end

    // Act on the word that came back from memory.
    if (cmd_i.run && rvld_q) begin
      unique case (op_q)
        OP_ALLOC: begin
          if (hit) begin
            wr_en      = 1'b1;
            wr_data    = rdata_q | (WORD_BITS'(1) << zero_bit);
            start_d    = rtag_q;
            res_addr_d = ADDR_W'({rtag_q, zero_bit}) << FRAME_SHIFT;
          end
        end
        OP_RELEASE: begin
          if (rdata_q[bit_q]) begin
            wr_en   = 1'b1;
            wr_data = rdata_q & ~(WORD_BITS'(1) << bit_q);
            start_d = rtag_q;
          end else begin
            res_status_d = ST_NOT_USED;
          end
        end
        OP_FREE_REGION: begin
          wr_en   = 1'b1;
          wr_data = rdata_q & ~reg_mask;
        end
        OP_RESERVE_REGION: begin
          wr_en   = 1'b1;
          wr_data = rdata_q | reg_mask;
        end
      endcase
    end

    // Failed pass: either start over from word zero or report out of memory.
    if (cmd_i.restart) begin
      ptr_d   = '0;
      start_d = '0;
    end else if (cmd_i.run && finished && (op_q == OP_ALLOC) && !hit && !retry) begin
      res_status_d = ST_OOM;
      res_addr_d   = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CFG_RESET;
      ptr_q       <= '0;
      lim_q       <= '0;
      start_q     <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
      ptr_q   <= ptr_d;
      lim_q   <= lim_d;
      start_q <= start_d;
      rvld_q  <= issue;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_opcode_i;
      addr_q <= in_addr_i;
      len_q  <= in_len_i;
    end
    bit_q        <= bit_d;
    hm1_q        <= hm1_d;
    first_word_q <= first_word_d;
    last_word_q  <= last_word_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    if (cmd_i.out_load) begin
      out_addr_q   <= res_addr_q;
      out_status_q <= res_status_q;
    end
  end

  // Bitmap memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rdata_q <= mem[ptr_q[WIDX-1:0]];
      rtag_q  <= ptr_q[WIDX-1:0];
    end
  end

  assign sts_o.clear_done = (ptr_q == WCNT'(BITMAP_WORDS - 1));
  assign sts_o.finished   = finished;
  assign sts_o.retry      = retry;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_addr_o   = out_addr_q;
  assign out_status_o = out_status_q;

endmodule

// File: hdl/bfa_ctrl.sv
module bfa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bfa_pkg::bfa_sts_t sts_i,
  output bfa_pkg::bfa_cmd_t cmd_o
);
  import bfa_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_PREP  = 5'b00100,
    S_RUN   = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Clearing pass after reset, then sequencing of one request: capture, prepare bounds, scan, hand off result.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_RUN;
      end
      S_RUN: begin
        cmd_o.run = 1'b1;
        if (sts_i.finished) begin
          if (sts_i.retry) begin
            cmd_o.restart = 1'b1;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sim/bitmap_frame_allocator_top_test.sv
`timescale 1ns / 100ps

module bitmap_frame_allocator_top_test;
  import bfa_pkg::*;

  // Longest stretch without any handshake before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 2000;
  // Receiver hold-off that fills the block and stalls its request side.
  localparam int unsigned LONG_HOLD = 240;
  // Quiet cycles after the last reply, longer than a wrapped search.
  localparam int unsigned TAIL_CYCLES = 150;
  localparam int unsigned MAX_PRINTS = 40;

  // One reply of the allocator.
  typedef struct packed {
    logic [ADDR_W-1:0] frame_address;
    status_e           status;
  } reply_t;

  // One line of the directed plan: either a register write or a request.
  typedef struct packed {
    bit                is_cfg;
    logic [CFG_W-1:0]  cfg_value;
    opcode_e           op;
    logic [31:0]       addr;
    logic [31:0]       len;
    bit                typed;
    logic [ADDR_W-1:0] want_addr;
    status_e           want_status;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  // byte_address [31:0], byte_length [63:32]
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  // opcode [1:0]
  logic [1:0]            s_axis_tuser_i = OP_ALLOC;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // frame_address [31:0]
  logic [ADDR_W-1:0]     m_axis_tdata_o;
  // status [1:0]
  logic [1:0]            m_axis_tuser_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_W-1:0]      cfg_data_i = CFG_RESET;

  // Typed expectation that travels beside the request being offered.
  bit                    row_typed = 1'b0;
  logic [ADDR_W-1:0]     row_want_addr = '0;
  status_e               row_want_status = ST_OK;

  // Mirror of the allocator state.
  logic [WORD_BITS-1:0]  model_bitmap [BITMAP_WORDS_DEF];
  logic [5:0]            model_start;
  logic [CFG_W-1:0]      model_words;

  reply_t                due_replies [$];
  logic [ADDR_W-1:0]     granted [$];
  int unsigned           mismatches = 0;
  int unsigned           quiet_cycles = 0;
  bit                    calm = 1'b0;
  bit                    stall_results = 1'b0;

  bitmap_frame_allocator_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    for (int w = 0; w < BITMAP_WORDS_DEF; w++) begin
      model_bitmap[w] = WORD_FULL;
    end
    model_start = '0;
    model_words = CFG_RESET;
  end

  // Words covered by memory; the register saturates at the bitmap depth.
  function automatic int unsigned live_word_count();
    return (model_words > BITMAP_WORDS_DEF) ? BITMAP_WORDS_DEF : model_words;
  endfunction

  // Lowest clear bit in the first non-full word of [from, limit).
  function automatic bit find_clear_frame(input int unsigned from, input int unsigned limit,
                                          output int unsigned frame);
    frame = 0;
    for (int unsigned w = from; w < limit; w++) begin
      if (model_bitmap[w] != WORD_FULL) begin
        for (int unsigned b = 0; b < WORD_BITS; b++) begin
          if (!model_bitmap[w][b]) begin
            model_start = 6'(w);
            frame = w * WORD_BITS + b;
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  // Applies one request to the mirror and works out its reply.
  function automatic void predict_request(input opcode_e op, input logic [31:0] addr,
                                          input logic [31:0] len,
                                          output logic [ADDR_W-1:0] frame_addr,
                                          output status_e st);
    int unsigned words;
    int unsigned frame;
    longint unsigned frames;
    longint unsigned first;
    longint unsigned count;
    longint unsigned last;
    bit found;
    words = live_word_count();
    frames = 64'(words * WORD_BITS);
    frame_addr = '0;
    st = ST_OK;
    case (op)
      OP_ALLOC: begin
        found = find_clear_frame(model_start, words, frame);
        if (!found && model_start != 0) begin
          model_start = '0;
          found = find_clear_frame(0, words, frame);
        end
        if (found) begin
          model_bitmap[frame / WORD_BITS][frame % WORD_BITS] = 1'b1;
          frame_addr = frame << FRAME_SHIFT;
        end else begin
          model_start = '0;
          st = ST_OOM;
        end
      end
      OP_RELEASE: begin
        first = 64'(addr >> FRAME_SHIFT);
        if (addr[FRAME_SHIFT-1:0] != '0 || first >= frames) begin
          st = ST_BAD_ADDR;
        end else if (!model_bitmap[first / WORD_BITS][first % WORD_BITS]) begin
          st = ST_NOT_USED;
        end else begin
          model_start = 6'(first / WORD_BITS);
          model_bitmap[first / WORD_BITS][first % WORD_BITS] = 1'b0;
        end
      end
      OP_FREE_REGION, OP_RESERVE_REGION: begin
        // Free rounds the length down, reserve rounds it up.
        count = 64'(len >> FRAME_SHIFT);
        if (op == OP_RESERVE_REGION && len[FRAME_SHIFT-1:0] != '0) begin
          count++;
        end
        first = 64'(addr >> FRAME_SHIFT);
        last = first + count;
        if (last > frames) begin
          last = frames;
        end
        for (longint unsigned f = first; f < last; f++) begin
          model_bitmap[f / WORD_BITS][f % WORD_BITS] = (op == OP_RESERVE_REGION);
        end
      end
    endcase
  endfunction

  function automatic plan_row_t req_row(input opcode_e op, input logic [31:0] addr,
                                        input logic [31:0] len);
    plan_row_t r;
    r = '0;
    r.op = op;
    r.addr = addr;
    r.len = len;
    return r;
  endfunction

  function automatic plan_row_t typed_row(input opcode_e op, input logic [31:0] addr,
                                          input logic [31:0] len,
                                          input logic [ADDR_W-1:0] want_addr,
                                          input status_e want_status);
    plan_row_t r;
    r = req_row(op, addr, len);
    r.typed = 1'b1;
    r.want_addr = want_addr;
    r.want_status = want_status;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_W-1:0] value);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.cfg_value = value;
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long; none in calm phases.
  function automatic int unsigned idle_span();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 50) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MAX_PRINTS) begin
      $display("%0t: %s: got 0x%08h, want 0x%08h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  // Mostly well-formed traffic around the frames in use, with some noise.
  task automatic pick_request(output opcode_e op, output logic [31:0] addr,
                              output logic [31:0] len);
    int unsigned span;
    int unsigned frame;
    int unsigned roll;
    int unsigned idx;
    span = live_word_count() * WORD_BITS;
    if (span == 0) begin
      span = WORD_BITS;
    end
    frame = $urandom_range(0, span - 1);
    roll = $urandom_range(0, 99);
    op = OP_ALLOC;
    addr = '0;
    len = '0;
    if (roll < 30) begin
      op = OP_ALLOC;
    end else if (roll < 50 && granted.size() != 0) begin
      op = OP_RELEASE;
      idx = $urandom_range(0, granted.size() - 1);
      addr = granted[idx];
      granted.delete(idx);
    end else if (roll < 60) begin
      op = OP_RELEASE;
      addr = frame << FRAME_SHIFT;
      if ($urandom_range(0, 7) == 0) begin
        addr = addr | $urandom_range(1, (1 << FRAME_SHIFT) - 1);
      end
    end else if (roll < 88) begin
      op = $urandom_range(0, 1) ? OP_FREE_REGION : OP_RESERVE_REGION;
      addr = frame << FRAME_SHIFT;
      if ($urandom_range(0, 3) == 0) begin
        addr = addr | $urandom_range(0, (1 << FRAME_SHIFT) - 1);
      end
      if (roll < 80) begin
        len = $urandom_range(0, 10 << FRAME_SHIFT);
      end else begin
        len = $urandom_range(0, span << FRAME_SHIFT);
      end
    end else begin
      op = opcode_e'($urandom_range(0, 3));
      addr = $urandom;
      len = $urandom;
    end
  endtask

  // Offers one request after a random gap and returns once it is taken.
  task automatic send_request(input opcode_e op, input logic [31:0] addr,
                              input logic [31:0] len, input bit typed,
                              input logic [ADDR_W-1:0] want_addr, input status_e want_status);
    int unsigned gap;
    gap = idle_span();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {len, addr};
    s_axis_tuser_i  <= op;
    row_typed       <= typed;
    row_want_addr   <= want_addr;
    row_want_status <= want_status;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Stops offering requests and waits for every outstanding reply.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (due_replies.size() != 0);
  endtask

  task automatic write_config(input logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Mirror update on each accepted request and check of each accepted reply.
  always @(posedge clk_i) begin : reply_check
    reply_t want;
    logic [ADDR_W-1:0] frame_addr;
    status_e st;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        model_words = cfg_data_i;
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_request(opcode_e'(s_axis_tuser_i), s_axis_tdata_i[31:0],
                        s_axis_tdata_i[63:32], frame_addr, st);
        if (opcode_e'(s_axis_tuser_i) == OP_ALLOC && st == ST_OK) begin
          granted.push_back(frame_addr);
        end
        if (row_typed) begin
          frame_addr = row_want_addr;
          st = row_want_status;
        end
        want.frame_address = frame_addr;
        want.status = st;
        due_replies.push_back(want);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (due_replies.size() == 0) begin
          report_mismatch("reply with no request outstanding", m_axis_tdata_o, '0);
        end else begin
          want = due_replies.pop_front();
          if (m_axis_tdata_o !== want.frame_address) begin
            report_mismatch("frame_address", m_axis_tdata_o, want.frame_address);
          end
          if (m_axis_tuser_o !== want.status) begin
            report_mismatch("status", 32'(m_axis_tuser_o), 32'(want.status));
          end
        end
      end
    end
  end

  // Hang detection: too many cycles without any handshake.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Reply side: random stalls, busy bursts, and one long hold-off on request.
  initial begin : reply_sink
    int unsigned span;
    @(posedge clk_i);
    forever begin
      if (stall_results) begin
        m_axis_tready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        stall_results = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        span = idle_span() + 1;
        repeat (span) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        span = $urandom_range(1, 12);
        repeat (span) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    plan_row_t plan [$];
    plan_row_t row;
    opcode_e op;
    logic [31:0] addr;
    logic [31:0] len;
    logic [CFG_W-1:0] words;
    int unsigned phase_items;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed plan. The bitmap starts with every frame used.
    plan.push_back(cfg_row(7'd64));
    plan.push_back(typed_row(OP_ALLOC, 32'h0, 32'h0, 32'h0, ST_OOM));
    plan.push_back(typed_row(OP_RELEASE, 32'h0000_0001, 32'h0, 32'h0, ST_BAD_ADDR));
    plan.push_back(typed_row(OP_RELEASE, 32'h0100_0000, 32'h0, 32'h0, ST_BAD_ADDR));
    plan.push_back(typed_row(OP_RELEASE, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'h0, ST_BAD_ADDR));
    plan.push_back(typed_row(OP_RELEASE, 32'h0, 32'h0, 32'h0, ST_OK));
    plan.push_back(typed_row(OP_RELEASE, 32'h0, 32'h0, 32'h0, ST_NOT_USED));
    plan.push_back(typed_row(OP_ALLOC, 32'h0, 32'h0, 32'h0, ST_OK));
    // Free rounds down to one frame, reserve rounds a single byte up to one.
    plan.push_back(req_row(OP_FREE_REGION, 32'h0, 32'h0000_1FFF));
    plan.push_back(req_row(OP_RESERVE_REGION, 32'h0000_2000, 32'h1));
    plan.push_back(typed_row(OP_FREE_REGION, 32'h0, 32'hFFFF_FFFF, 32'h0, ST_OK));
    plan.push_back(req_row(OP_ALLOC, 32'h0, 32'h0));
    plan.push_back(req_row(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    plan.push_back(typed_row(OP_RESERVE_REGION, 32'h0, 32'hFFFF_FFFF, 32'h0, ST_OK));
    plan.push_back(typed_row(OP_ALLOC, 32'h0, 32'h0, 32'h0, ST_OOM));
    plan.push_back(typed_row(OP_FREE_REGION, 32'h00FF_F000, 32'h1000, 32'h0, ST_OK));
    plan.push_back(typed_row(OP_ALLOC, 32'h0, 32'h0, 32'h00FF_F000, ST_OK));
    // A region that lies wholly past the last frame changes nothing.
    plan.push_back(typed_row(OP_FREE_REGION, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'h0, ST_OK));
    plan.push_back(req_row(OP_FREE_REGION, 32'h0000_5000, 32'h1000));
    // Shrinking memory leaves the search start past the end; it wraps to word 0.
    plan.push_back(cfg_row(7'd2));
    plan.push_back(req_row(OP_ALLOC, 32'h0, 32'h0));
    // With no words in use nothing can be allocated or released.
    plan.push_back(cfg_row(7'd0));
    plan.push_back(typed_row(OP_ALLOC, 32'h0, 32'h0, 32'h0, ST_OOM));
    plan.push_back(typed_row(OP_RELEASE, 32'h0, 32'h0, 32'h0, ST_BAD_ADDR));
    plan.push_back(typed_row(OP_RESERVE_REGION, 32'h0, 32'hFFFF_FFFF, 32'h0, ST_OK));
    // A register above the bitmap depth saturates.
    plan.push_back(cfg_row(7'd127));
    plan.push_back(typed_row(OP_RELEASE, 32'h00FF_F000, 32'h0, 32'h0, ST_OK));
    plan.push_back(typed_row(OP_RELEASE, 32'h0100_0000, 32'h0, 32'h0, ST_BAD_ADDR));
    plan.push_back(typed_row(OP_RESERVE_REGION, 32'h0000_3000, 32'h0, 32'h0, ST_OK));
    plan.push_back(req_row(OP_ALLOC, 32'h0, 32'h0));

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) begin
        wait_drained();
        write_config(row.cfg_value);
      end else begin
        send_request(row.op, row.addr, row.len, row.typed, row.want_addr, row.want_status);
      end
    end

    // Random phases, each under its own memory size.
    for (int phase = 0; phase < 11; phase++) begin
      case (phase)
        0: words = 7'd1;
        1: words = 7'd64;
        2: words = 7'd127;
        3: words = 7'd0;
        4: words = 7'd2;
        default: words = ($urandom_range(0, 3) == 0) ? 7'd64 : 7'($urandom_range(1, 127));
      endcase
      phase_items = (phase == 3) ? 10 : 54;
      wait_drained();
      write_config(words);
      // One phase floods the block while replies are held back, one runs gap-free.
      calm = (phase == 5 || phase == 6);
      stall_results = (phase == 6);
      for (int n = 0; n < phase_items; n++) begin
        pick_request(op, addr, len);
        send_request(op, addr, len, 1'b0, '0, ST_OK);
      end
      calm = 1'b0;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
